>>> hw/rtl/pfr_pkg.sv
// shared types, constants and codes for the programmable state machine
package pfr_pkg;

  localparam int NUM_STATES  = 8;
  localparam int SLOTS       = 8;
  localparam int LIVE_STATES = (NUM_STATES < SLOTS) ? NUM_STATES : SLOTS;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int TABLE_W     = 2 * IDX_W * SLOTS;
  localparam logic [SLOTS-1:0] LIVE_MASK = SLOTS'((1 << LIVE_STATES) - 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    OP_STEP0    = 3'd0,
    OP_STEP1    = 3'd1,
    OP_RETARGET = 3'd2,
    OP_QUERY    = 3'd3,
    OP_DEL_ALL  = 3'd4,
    OP_DEL_ONE  = 3'd5,
    OP_READ     = 3'd6,
    OP_RESTART  = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;

  typedef struct packed {
    op_t              op;
    logic             sel;
    logic [IDX_W-1:0] tgt;
    logic             pre_walk;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK_PRE,
    S_APPLY,
    S_WALK_POST
  } back_state_t;

endpackage

>>> hw/rtl/pfr_if.sv
// handshake channels for command beats and result beats
interface pfr_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic       bit_select;
  logic [2:0] target_state;

  modport source (output valid, output operation, output bit_select, output target_state,
                  input ready);
  modport sink (input valid, input operation, input bit_select, input target_state,
                output ready);
endinterface

interface pfr_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] current_node;
  logic [7:0] unreachable_mask;
  logic [7:0] deleted_now_mask;
  logic [1:0] status;
  logic [2:0] entry_next_zero;
  logic [2:0] entry_next_one;
  logic       entry_deleted;

  modport source (output valid, output current_node, output unreachable_mask,
                  output deleted_now_mask, output status, output entry_next_zero,
                  output entry_next_one, output entry_deleted, input ready);
  modport sink (input valid, input current_node, input unreachable_mask,
                input deleted_now_mask, input status, input entry_next_zero,
                input entry_next_one, input entry_deleted, output ready);
endinterface

>>> hw/rtl/pfr_front.sv
// command intake: decodes each beat and holds it in a short queue for the back end
module pfr_front import pfr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  pfr_cmd_if.sink cmd,
  output cmd_t  q_head,
  output logic  q_valid,
  input  logic  q_pop
);

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  cmd_t              decoded;
  logic              push;
  logic              pop;

  always_comb begin
    decoded.op       = op_t'(cmd.operation);
    decoded.sel      = cmd.bit_select;
    decoded.tgt      = cmd.target_state;
    // deletes need the reachability of the state before the change
    decoded.pre_walk = cmd.operation inside {OP_DEL_ALL, OP_DEL_ONE};
  end

  assign cmd.ready = (count != QCNT_W'(QDEPTH));
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != '0);
  assign pop       = q_pop && q_valid;
  assign q_head    = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hw/rtl/pfr_back.sv
// execution side: transition table, deletion flags, reachability walk and result register
module pfr_back import pfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               q_head,
  input  logic               q_valid,
  output logic               q_pop,
  input  logic [TABLE_W-1:0] init_table,
  pfr_res_if.source          res
);

  logic [IDX_W-1:0] nz [SLOTS];
  logic [IDX_W-1:0] no [SLOTS];
  logic [SLOTS-1:0] deleted;
  logic [IDX_W-1:0] cur;
  logic [SLOTS-1:0] mark;
  cmd_t             cmd_q;
  back_state_t      state;
  back_state_t      state_next;

  logic [SLOTS-1:0] killed_q;
  logic [1:0]       status_q;
  logic [IDX_W-1:0] e0_q;
  logic [IDX_W-1:0] e1_q;
  logic             ed_q;

  logic [SLOTS-1:0] grown;
  logic             settled;
  logic             load_out;
  logic             tgt_ok;
  logic [SLOTS-1:0] unreach_pre;
  logic [IDX_W-1:0] cur_new;
  logic [SLOTS-1:0] killed_new;
  logic [1:0]       status_new;
  logic [IDX_W-1:0] e0_new;
  logic [IDX_W-1:0] e1_new;
  logic             ed_new;
  logic             rt_en;

  function automatic logic [IDX_W-1:0] clamp_idx(logic [IDX_W-1:0] v);
    return ({1'b0, v} < (IDX_W + 1)'(LIVE_STATES)) ? v : '0;
  endfunction

  // one level of the marking walk: every live marked state marks its successors
  always_comb begin
    grown = mark;
    for (int i = 0; i < SLOTS; i++) begin
      if (mark[i] && LIVE_MASK[i]) begin
        grown = grown | (SLOTS'(1) << nz[i]) | (SLOTS'(1) << no[i]);
      end
    end
  end

  assign settled  = (grown == mark);
  assign load_out = (state == S_WALK_POST) && settled && (!res.valid || res.ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          state_next = q_head.pre_walk ? S_WALK_PRE : S_APPLY;
        end
      end
      S_WALK_PRE: begin
        if (settled) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY:     state_next = S_WALK_POST;
      S_WALK_POST: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == S_IDLE);
  end

  // effect of the held command on table, flags and current state
  always_comb begin
    tgt_ok      = ({1'b0, cmd_q.tgt} < (IDX_W + 1)'(LIVE_STATES));
    unreach_pre = LIVE_MASK & ~mark;
    cur_new     = cur;
    killed_new  = '0;
    status_new  = ST_OK;
    e0_new      = '0;
    e1_new      = '0;
    ed_new      = 1'b0;
    rt_en       = 1'b0;
    case (cmd_q.op)
      OP_STEP0: cur_new = nz[cur];
      OP_STEP1: cur_new = no[cur];
      OP_RETARGET: begin
        if (!tgt_ok || deleted[cmd_q.tgt]) begin
          status_new = ST_REFUSED;
        end else begin
          rt_en = 1'b1;
        end
      end
      OP_QUERY: ;
      OP_DEL_ALL: begin
        killed_new = unreach_pre & ~deleted;
        if (killed_new == '0) begin
          status_new = ST_NONE;
        end
      end
      OP_DEL_ONE: begin
        if (tgt_ok && unreach_pre[cmd_q.tgt] && !deleted[cmd_q.tgt]) begin
          killed_new = SLOTS'(1) << cmd_q.tgt;
        end else begin
          status_new = ST_NONE;
        end
      end
      OP_READ: begin
        if (tgt_ok) begin
          e0_new = nz[cmd_q.tgt];
          e1_new = no[cmd_q.tgt];
          ed_new = deleted[cmd_q.tgt];
        end
      end
      OP_RESTART: cur_new = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cur     <= '0;
      deleted <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        nz[i] <= '0;
        no[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_APPLY) begin
        cur <= cur_new;
        if (rt_en) begin
          if (cmd_q.sel) begin
            no[cur] <= cmd_q.tgt;
          end else begin
            nz[cur] <= cmd_q.tgt;
          end
        end
        if (cmd_q.op == OP_RESTART) begin
          deleted <= '0;
          for (int i = 0; i < SLOTS; i++) begin
            nz[i] <= clamp_idx(init_table[2*IDX_W*i +: IDX_W]);
            no[i] <= clamp_idx(init_table[2*IDX_W*i + IDX_W +: IDX_W]);
          end
        end else begin
          deleted <= deleted | killed_new;
        end
      end
    end
  end

  // command hold, walk marks and per-beat results
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd_q <= q_head;
        mark  <= SLOTS'(1) << cur;
      end
      S_WALK_PRE, S_WALK_POST: mark <= grown;
      S_APPLY: begin
        mark     <= SLOTS'(1) << cur_new;
        killed_q <= killed_new;
        status_q <= status_new;
        e0_q     <= e0_new;
        e1_q     <= e1_new;
        ed_q     <= ed_new;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load_out) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.current_node     <= cur;
      res.unreachable_mask <= LIVE_MASK & ~mark;
      res.deleted_now_mask <= killed_q;
      res.status           <= status_q;
      res.entry_next_zero  <= e0_q;
      res.entry_next_one   <= e1_q;
      res.entry_deleted    <= ed_q;
    end
  end

endmodule

>>> hw/rtl/programmable_fsm_with_reachability.sv
// programmable eight-state machine: each command beat yields one result beat
// per command the back end pops it in S_IDLE, applies it in S_APPLY and then walks in S_WALK_POST;
// deletes also walk in S_WALK_PRE before the apply, one reachability level per cycle
// the back end works on one command at a time, its pace set by the marking walk; a 2-beat queue
// lets commands arrive while one is at work and the result register waits to be taken
// reset clears the table to all zero, the deleted flags, the queue and returns to state A
module programmable_fsm_with_reachability import pfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [TABLE_W-1:0] cfg_data,
  pfr_cmd_if.sink            cmd,
  pfr_res_if.source          res
);

  logic [TABLE_W-1:0] init_table;
  cmd_t               q_head;
  logic               q_valid;
  logic               q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_table <= '0;
    end else if (cfg_we) begin
      init_table <= cfg_data;
    end
  end

  pfr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_head  (q_head),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  pfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_head     (q_head),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .init_table (init_table),
    .res        (res)
  );

  // states deleted by a beat were unreachable and stay so
  a_killed_unreach: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.deleted_now_mask & ~res.unreachable_mask) == '0)
    else $error("deleted state reported reachable");

  // the current state always reaches itself
  a_cur_reach: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !res.unreachable_mask[res.current_node])
    else $error("current state reported unreachable");

  a_kill_status: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.deleted_now_mask != '0 |-> res.status == ST_OK)
    else $error("deletion with non-ok status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.status == ST_OK || res.status == ST_REFUSED || res.status == ST_NONE)
    else $error("undefined status code");

endmodule

>>> tb/tb.sv
// self-checking bench for the programmable state machine: predictor, scoreboard and handshake drivers
module tb;
  import pfr_pkg::*;

  localparam int DRAIN_CYCLES    = 25;
  localparam int STALL_LIMIT     = 3000;
  localparam int ITEMS_PER_BLOCK = 52;
  localparam int HOLD_CYCLES     = 80;

  typedef struct packed {
    logic [IDX_W-1:0] node;
    logic [SLOTS-1:0] unreach;
    logic [SLOTS-1:0] killed;
    logic [1:0]       status;
    logic [IDX_W-1:0] e0;
    logic [IDX_W-1:0] e1;
    logic             ed;
  } fsm_result_t;

  class fsm_scoreboard;
    logic [TABLE_W-1:0] boot_table;
    logic [IDX_W-1:0]   succ0 [SLOTS];
    logic [IDX_W-1:0]   succ1 [SLOTS];
    logic [SLOTS-1:0]   gone;
    logic [IDX_W-1:0]   here;
    fsm_result_t        expected_q [$];
    int unsigned        mismatches;

    function new();
      boot_table = '0;
      foreach (succ0[i]) begin
        succ0[i] = '0;
        succ1[i] = '0;
      end
      gone = '0;
      here = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [IDX_W-1:0] clamp_idx(logic [IDX_W-1:0] v);
      return (int'(v) < LIVE_STATES) ? v : '0;
    endfunction

    // marking fixpoint, one level per round
    function logic [SLOTS-1:0] reach_set(logic [IDX_W-1:0] origin);
      logic [SLOTS-1:0] mark;
      logic [SLOTS-1:0] grown;
      mark = '0;
      mark[origin] = 1'b1;
      for (int round = 0; round < SLOTS; round++) begin
        grown = mark;
        for (int i = 0; i < LIVE_STATES; i++) begin
          if (mark[i]) begin
            grown[succ0[i]] = 1'b1;
            grown[succ1[i]] = 1'b1;
          end
        end
        if (grown == mark) break;
        mark = grown;
      end
      return mark;
    endfunction

    // an unreachable live state not yet deleted, else any index
    function logic [IDX_W-1:0] pick_victim();
      logic [SLOTS-1:0] cand;
      int k;
      cand = LIVE_MASK & ~reach_set(here) & ~gone;
      k = $urandom_range(SLOTS - 1);
      if (cand == '0) return IDX_W'(k);
      while (!cand[k]) k = (k + 1) % SLOTS;
      return IDX_W'(k);
    endfunction

    function void note_command(op_t op, logic sel, logic [IDX_W-1:0] tgt);
      fsm_result_t r;
      logic [SLOTS-1:0] unreach;
      logic tgt_ok;
      r = '0;
      r.status = ST_OK;
      tgt_ok = int'(tgt) < LIVE_STATES;
      unreach = LIVE_MASK & ~reach_set(here);
      case (op)
        OP_STEP0: here = succ0[here];
        OP_STEP1: here = succ1[here];
        OP_RETARGET: begin
          if (!tgt_ok || gone[tgt]) r.status = ST_REFUSED;
          else if (sel) succ1[here] = tgt;
          else succ0[here] = tgt;
        end
        OP_QUERY: ;
        OP_DEL_ALL: begin
          r.killed = unreach & ~gone;
          gone |= r.killed;
          if (r.killed == '0) r.status = ST_NONE;
        end
        OP_DEL_ONE: begin
          if (tgt_ok && unreach[tgt] && !gone[tgt]) begin
            r.killed[tgt] = 1'b1;
            gone[tgt] = 1'b1;
          end else begin
            r.status = ST_NONE;
          end
        end
        OP_READ: begin
          if (tgt_ok) begin
            r.e0 = succ0[tgt];
            r.e1 = succ1[tgt];
            r.ed = gone[tgt];
          end
        end
        OP_RESTART: begin
          for (int i = 0; i < SLOTS; i++) begin
            succ0[i] = clamp_idx(boot_table[2*IDX_W*i +: IDX_W]);
            succ1[i] = clamp_idx(boot_table[2*IDX_W*i + IDX_W +: IDX_W]);
          end
          gone = '0;
          here = '0;
        end
        default: ;
      endcase
      r.node = here;
      r.unreach = LIVE_MASK & ~reach_set(here);
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(fsm_result_t got);
      fsm_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, expected none actual node %0h",
                 $time, got.node);
        return;
      end
      want = expected_q.pop_front();
      compare_field("current_node", want.node, got.node);
      compare_field("unreachable_mask", want.unreach, got.unreach);
      compare_field("deleted_now_mask", want.killed, got.killed);
      compare_field("status", want.status, got.status);
      compare_field("entry_next_zero", want.e0, got.e0);
      compare_field("entry_next_one", want.e1, got.e1);
      compare_field("entry_deleted", want.ed, got.ed);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [TABLE_W-1:0] cfg_data = '0;

  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 51;
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;

  fsm_scoreboard sb = new();

  pfr_cmd_if cmd_ch ();
  pfr_res_if res_ch ();

  programmable_fsm_with_reachability u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd_ch),
    .res      (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.operation = OP_QUERY;
    cmd_ch.bit_select = 1'b0;
    cmd_ch.target_state = '0;
  end

  task automatic send_cmd(input op_t op, input logic sel, input logic [IDX_W-1:0] tgt);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.bit_select <= sel;
    cmd_ch.target_state <= tgt;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sb.note_command(op, sel, tgt);
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_boot_table(input logic [TABLE_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.boot_table = value;
  endtask

  task automatic send_random_cmd();
    int unsigned r;
    op_t op;
    logic sel;
    logic [IDX_W-1:0] tgt;
    r = $urandom_range(99);
    sel = 1'($urandom_range(1));
    tgt = IDX_W'($urandom_range(SLOTS - 1));
    if (r < 20) op = OP_STEP0;
    else if (r < 40) op = OP_STEP1;
    else if (r < 58) op = OP_RETARGET;
    else if (r < 63) op = OP_QUERY;
    else if (r < 70) op = OP_DEL_ALL;
    else if (r < 82) begin
      op = OP_DEL_ONE;
      // aim most single deletes at a state that can actually go
      if ($urandom_range(3) != 0) tgt = sb.pick_victim();
    end else if (r < 95) op = OP_READ;
    else op = OP_RESTART;
    send_cmd(op, sel, tgt);
  endtask

  // result side: check every beat, choose ready for the next edge
  initial begin
    fsm_result_t got;
    int unsigned hold_left;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        got = {res_ch.current_node, res_ch.unreachable_mask, res_ch.deleted_now_mask,
               res_ch.status, res_ch.entry_next_zero, res_ch.entry_next_one,
               res_ch.entry_deleted};
        sb.check_result(got);
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [TABLE_W-1:0] ring;
    logic [TABLE_W-1:0] plan;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset table is all zero: everything but A is unreachable
    send_cmd(OP_QUERY, 1'b1, 3'd7);

    // bit 0 walks a ring, bit 1 stays put
    ring = '0;
    for (int i = 0; i < SLOTS; i++) begin
      ring[2*IDX_W*i +: IDX_W] = IDX_W'((i + 1) % SLOTS);
      ring[2*IDX_W*i + IDX_W +: IDX_W] = IDX_W'(i);
    end
    write_boot_table(ring);
    send_cmd(OP_RESTART, 1'b0, 3'd0);
    send_cmd(OP_READ, 1'b0, 3'd0);
    send_cmd(OP_READ, 1'b1, 3'd7);
    send_cmd(OP_STEP0, 1'b0, 3'd0);
    send_cmd(OP_STEP1, 1'b1, 3'd0);
    send_cmd(OP_RESTART, 1'b1, 3'd5);
    // isolate A, then carve states away
    send_cmd(OP_RETARGET, 1'b0, 3'd0);
    send_cmd(OP_DEL_ONE, 1'b0, 3'd0);
    send_cmd(OP_DEL_ONE, 1'b0, 3'd2);
    send_cmd(OP_DEL_ONE, 1'b1, 3'd2);
    send_cmd(OP_RETARGET, 1'b1, 3'd2);
    // a live state that leads into a deleted one
    send_cmd(OP_RETARGET, 1'b1, 3'd1);
    send_cmd(OP_READ, 1'b0, 3'd2);
    send_cmd(OP_STEP1, 1'b0, 3'd0);
    send_cmd(OP_STEP0, 1'b1, 3'd7);
    send_cmd(OP_DEL_ALL, 1'b0, 3'd0);
    send_cmd(OP_RESTART, 1'b0, 3'd0);
    send_cmd(OP_RETARGET, 1'b0, 3'd0);
    send_cmd(OP_RETARGET, 1'b1, 3'd0);
    send_cmd(OP_DEL_ALL, 1'b1, 3'd7);
    send_cmd(OP_DEL_ALL, 1'b0, 3'd0);
    send_cmd(OP_RETARGET, 1'b1, 3'd7);
    send_cmd(OP_STEP0, 1'b1, 3'd3);
    send_cmd(OP_READ, 1'b1, 3'd7);

    for (int mode = 0; mode < 3; mode++) begin
      for (int blk = 0; blk < 3; blk++) begin
        case (mode * 3 + blk)
          0: plan = '0;
          1: plan = '1;
          default: plan = TABLE_W'({$urandom, $urandom});
        endcase
        write_boot_table(plan);
        case (mode)
          0: begin
            send_idle_pct = 16;
            recv_idle_pct = 51;
          end
          1: begin
            send_idle_pct = 51;
            recv_idle_pct = 16;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
        send_cmd(OP_RESTART, 1'($urandom_range(1)), IDX_W'($urandom_range(SLOTS - 1)));
        // long result back-pressure while commands keep coming
        if (mode == 2 && blk == 0) hold_request = 1'b1;
        repeat (ITEMS_PER_BLOCK) send_random_cmd();
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> programmable_fsm_with_reachability.f
hw/rtl/pfr_pkg.sv
hw/rtl/pfr_if.sv
hw/rtl/pfr_front.sv
hw/rtl/pfr_back.sv
hw/rtl/programmable_fsm_with_reachability.sv
tb/tb.sv
